// File: rtl/core/fdsl_pkg.sv
`default_nettype none

package fdsl_pkg;

   // Serial word length and counter widths
   localparam int SHIFT_BITS = 24;
   localparam int BIT_CNT_W  = $clog2(SHIFT_BITS + 1);
   localparam int DELAY_W    = 10;

   // Last pass index of one load and the latch bits ORed in on the second pass
   localparam logic [1:0]            PASS_LAST   = 2'd2;
   localparam logic [1:0]            PASS_LATCH  = 2'd1;
   localparam logic [SHIFT_BITS-1:0] LATCH_BITS  = 24'h000880;

   // Tick phases within one bit
   localparam logic [1:0] PHASE_DATA  = 2'd0;
   localparam logic [1:0] PHASE_CLOCK = 2'd1;
   localparam logic [1:0] PHASE_HOLD  = 2'd2;

   // Request codes
   typedef enum logic [1:0] {
      OP_SET_DELAY  = 2'd0,
      OP_SET_ENABLE = 2'd1,
      OP_TICK       = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic               channel;
      logic [DELAY_W-1:0] delay_value;
      logic               enable_flag;
   } req_type;

   typedef struct packed {
      logic               data_pin;
      logic               shift_clock_pin;
      logic               latch_clock_pin;
      logic               disable_pin;
      logic               busy_res;
      logic [DELAY_W-1:0] delay_ch0;
      logic [DELAY_W-1:0] delay_ch1;
      logic               rejected;
   } rsp_type;

   // Pack both delays into the shift word
   function automatic logic [SHIFT_BITS-1:0] pack_word(
      input logic [DELAY_W-1:0] d0,
      input logic [DELAY_W-1:0] d1
   );
      logic [SHIFT_BITS-1:0] w;
      w = '0;
      w[23:16] = d1[7:0];
      w[15:12] = d0[3:0];
      w[9:8]   = d1[9:8];
      w[5:0]   = d0[9:4];
      return w;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/fdsl_chan.sv
`default_nettype none

// Valid/ready channel carrying one beat of payload
interface fdsl_chan #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fine_delay_serial_loader.sv
`default_nettype none

// Pin sequencer for a two-channel fine delay module. Each request beat yields
// exactly one response beat, one beat per clock at full rate: the request is
// applied to the sequencer state and the pin levels are captured in the
// response register in the same cycle, so the only limit is the downstream
// ready. A set-delay starts a three-pass load of the 24-bit word (3 ticks per
// bit plus a latch tick and an idle tick per pass, 222 ticks in all); a
// set-delay during a load is refused and flagged. Ticks while idle leave all
// serial pins low.
module fine_delay_serial_loader (
   input  wire logic    clock,
   input  wire logic    reset,
   fdsl_chan.sink       req_chan,
   fdsl_chan.source     rsp_chan
);
   import fdsl_pkg::*;

   // Sequencer state
   logic [DELAY_W-1:0]    delay_store_ff [2];
   logic [DELAY_W-1:0]    delay_store_in [2];
   logic [SHIFT_BITS-1:0] shift_word_ff, shift_word_in;
   logic [BIT_CNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [1:0]            tick_phase_ff, tick_phase_in;
   logic [1:0]            pass_count_ff, pass_count_in;
   logic                  load_active_ff, load_active_in;
   logic                  disable_ff, disable_in;

   // Response register
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff;

   logic                  accept;
   logic [SHIFT_BITS-1:0] word_eff;
   logic [BIT_CNT_W-1:0]  bit_idx;
   logic                  din, sclk, lclk, rej;

   // Take a new beat whenever the response slot is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   assign word_eff = (pass_count_ff == PASS_LATCH) ? (shift_word_ff | LATCH_BITS)
                                                   : shift_word_ff;
   assign bit_idx  = BIT_CNT_W'(SHIFT_BITS - 1) - bit_count_ff;

   // Next state and pin levels for the request beat
   always_comb begin
      delay_store_in = delay_store_ff;
      shift_word_in  = shift_word_ff;
      bit_count_in   = bit_count_ff;
      tick_phase_in  = tick_phase_ff;
      pass_count_in  = pass_count_ff;
      load_active_in = load_active_ff;
      disable_in     = disable_ff;
      din  = 1'b0;
      sclk = 1'b0;
      lclk = 1'b0;
      rej  = 1'b0;

      case (req_chan.data.operation)
         OP_SET_DELAY: begin
            if (load_active_ff) begin
               rej = 1'b1;
            end else begin
               delay_store_in[req_chan.data.channel] = req_chan.data.delay_value;
               shift_word_in  = pack_word(delay_store_in[0], delay_store_in[1]);
               bit_count_in   = '0;
               tick_phase_in  = PHASE_DATA;
               pass_count_in  = '0;
               load_active_in = 1'b1;
            end
         end
         OP_SET_ENABLE: begin
            disable_in = !req_chan.data.enable_flag;
         end
         OP_TICK: begin
            if (load_active_ff) begin
               if (bit_count_ff < BIT_CNT_W'(SHIFT_BITS)) begin
                  // data, data with shift clock, data
                  din  = word_eff[bit_idx];
                  sclk = (tick_phase_ff == PHASE_CLOCK);
                  if (tick_phase_ff >= PHASE_HOLD) begin
                     tick_phase_in = PHASE_DATA;
                     bit_count_in  = bit_count_ff + 1'b1;
                  end else begin
                     tick_phase_in = tick_phase_ff + 1'b1;
                  end
               end else if (tick_phase_ff == PHASE_DATA) begin
                  // latch pulse
                  lclk          = 1'b1;
                  tick_phase_in = PHASE_CLOCK;
               end else begin
                  // idle tick closes the pass
                  tick_phase_in = PHASE_DATA;
                  bit_count_in  = '0;
                  if (pass_count_ff == PASS_LAST) begin
                     pass_count_in  = '0;
                     load_active_in = 1'b0;
                  end else begin
                     pass_count_in = pass_count_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      rsp_data_in.data_pin        = din;
      rsp_data_in.shift_clock_pin = sclk;
      rsp_data_in.latch_clock_pin = lclk;
      rsp_data_in.disable_pin     = disable_in;
      rsp_data_in.busy_res        = load_active_in;
      rsp_data_in.delay_ch0       = delay_store_in[0];
      rsp_data_in.delay_ch1       = delay_store_in[1];
      rsp_data_in.rejected        = rej;
   end

   // State and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_store_ff[0] <= '0;
         delay_store_ff[1] <= '0;
         shift_word_ff     <= '0;
         bit_count_ff      <= '0;
         tick_phase_ff     <= PHASE_DATA;
         pass_count_ff     <= '0;
         load_active_ff    <= 1'b0;
         disable_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            delay_store_ff <= delay_store_in;
            shift_word_ff  <= shift_word_in;
            bit_count_ff   <= bit_count_in;
            tick_phase_ff  <= tick_phase_in;
            pass_count_ff  <= pass_count_in;
            load_active_ff <= load_active_in;
            disable_ff     <= disable_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// File: tb/fine_delay_serial_loader_test.sv
`default_nettype none

module fine_delay_serial_loader_test;
   import fdsl_pkg::*;

   // Unused request code: the block must leave its state alone
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 750;
   localparam int QUIET_AFTER  = 680;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 60;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;

   fdsl_chan #(.payload_type(req_type)) req_chan ();
   fdsl_chan #(.payload_type(rsp_type)) rsp_chan ();

   fine_delay_serial_loader i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the pin sequencer
   logic [DELAY_W-1:0]    delay_shadow [2];
   logic [SHIFT_BITS-1:0] word_shadow;
   logic [4:0]            bit_idx;
   logic [1:0]            phase;
   logic [1:0]            pass_idx;
   bit                    loading;
   bit                    disabled;

   rsp_type      expected_pins [$];
   stim_row_type stim_rows [$];
   int           mismatch_count = 0;
   int           beats_checked  = 0;
   int           beats_sent     = 0;
   int           loads_done     = 0;
   int           refusals       = 0;
   int           cycle_count    = 0;
   bit           quiet          = 1'b0;

   initial clock = 1'b0;
   always begin
      #5 clock = ~clock;
   end

   // Predict one response beat and advance the shadow state
   function automatic rsp_type pin_sequence_step(input req_type r);
      rsp_type               o;
      logic [SHIFT_BITS-1:0] w;
      o = '0;
      case (r.operation)
         OP_SET_DELAY: begin
            if (loading) begin
               o.rejected = 1'b1;
               refusals++;
            end else begin
               delay_shadow[r.channel] = r.delay_value;
               word_shadow = {delay_shadow[1][7:0], delay_shadow[0][3:0], 2'b00,
                              delay_shadow[1][9:8], 2'b00, delay_shadow[0][9:4]};
               bit_idx  = '0;
               phase    = PHASE_DATA;
               pass_idx = '0;
               loading  = 1'b1;
            end
         end
         OP_SET_ENABLE: begin
            disabled = !r.enable_flag;
         end
         OP_TICK: begin
            if (loading) begin
               if (bit_idx < SHIFT_BITS) begin
                  w = word_shadow | ((pass_idx == PASS_LATCH) ? LATCH_BITS : '0);
                  o.data_pin        = w[SHIFT_BITS-1-bit_idx];
                  o.shift_clock_pin = (phase == PHASE_CLOCK);
                  if (phase == PHASE_HOLD) begin
                     phase = PHASE_DATA;
                     bit_idx++;
                  end else begin
                     phase++;
                  end
               end else if (phase == PHASE_DATA) begin
                  o.latch_clock_pin = 1'b1;
                  phase = PHASE_CLOCK;
               end else begin
                  phase   = PHASE_DATA;
                  bit_idx = '0;
                  if (pass_idx == PASS_LAST) begin
                     pass_idx = '0;
                     loading  = 1'b0;
                     loads_done++;
                  end else begin
                     pass_idx++;
                  end
               end
            end
         end
         default: ;
      endcase
      o.disable_pin = disabled;
      o.busy_res    = loading;
      o.delay_ch0   = delay_shadow[0];
      o.delay_ch1   = delay_shadow[1];
      return o;
   endfunction

   function automatic rsp_type pins(input bit din, input bit sclk, input bit lclk,
                                    input bit dis, input bit busy,
                                    input logic [DELAY_W-1:0] d0,
                                    input logic [DELAY_W-1:0] d1, input bit rej);
      rsp_type o;
      o.data_pin        = din;
      o.shift_clock_pin = sclk;
      o.latch_clock_pin = lclk;
      o.disable_pin     = dis;
      o.busy_res        = busy;
      o.delay_ch0       = d0;
      o.delay_ch1       = d1;
      o.rejected        = rej;
      return o;
   endfunction

   function automatic void add_row(input logic [1:0] op, input bit ch,
                                   input logic [DELAY_W-1:0] dv, input bit en,
                                   input bit known, input rsp_type rsp);
      stim_row_type row;
      row.req.operation   = op;
      row.req.channel     = ch;
      row.req.delay_value = dv;
      row.req.enable_flag = en;
      row.known           = known;
      row.rsp             = rsp;
      stim_rows.push_back(row);
   endfunction

   // Send one request beat, with an occasional gap in front of it
   task automatic send_beat(input req_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= r;
      do @(posedge clock); while (!req_chan.ready);
      beats_sent++;
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Response checker
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.data;
         if (expected_pins.size() == 0) begin
            $display("%0t: response beat with none expected, got %h", $time, got);
            mismatch_count++;
         end else begin
            want = expected_pins.pop_front();
            report_field("data_pin", want.data_pin, got.data_pin);
            report_field("shift_clock_pin", want.shift_clock_pin, got.shift_clock_pin);
            report_field("latch_clock_pin", want.latch_clock_pin, got.latch_clock_pin);
            report_field("disable_pin", want.disable_pin, got.disable_pin);
            report_field("busy_res", want.busy_res, got.busy_res);
            report_field("delay_ch0", want.delay_ch0, got.delay_ch0);
            report_field("delay_ch1", want.delay_ch1, got.delay_ch1);
            report_field("rejected", want.rejected, got.rejected);
         end
         beats_checked++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, expected_pins.size());
         $display("fine_delay_serial_loader_test failed");
         $finish;
      end
   end

   // Response side: random stalls, one long hold-off, then steady ready
   initial begin
      bit held;
      held = 1'b0;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && beats_checked >= HOLD_AFTER) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_chan.ready <= 1'b1;
            repeat (quiet ? 1 : $urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   // Reset and request stimulus
   initial begin
      req_type             r;
      int                  useful;
      int                  pick;
      logic [DELAY_W-1:0]  dv;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      delay_shadow[0] = '0;
      delay_shadow[1] = '0;
      word_shadow = '0;
      bit_idx     = '0;
      phase       = PHASE_DATA;
      pass_idx    = '0;
      loading     = 1'b0;
      disabled    = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: an idle tick, enable both ways, unused code, a load with refused set-delays
      add_row(OP_TICK, 1'b0, 10'h000, 1'b0, 1'b1, pins(0, 0, 0, 0, 0, 0, 0, 0));
      add_row(OP_UNUSED, 1'b0, 10'h000, 1'b0, 1'b1, pins(0, 0, 0, 0, 0, 0, 0, 0));
      add_row(OP_SET_ENABLE, 1'b0, 10'h000, 1'b0, 1'b1, pins(0, 0, 0, 1, 0, 0, 0, 0));
      add_row(OP_UNUSED, 1'b1, 10'h3ff, 1'b1, 1'b1, pins(0, 0, 0, 1, 0, 0, 0, 0));
      add_row(OP_SET_ENABLE, 1'b1, 10'h3ff, 1'b1, 1'b1, pins(0, 0, 0, 0, 0, 0, 0, 0));
      add_row(OP_SET_DELAY, 1'b1, 10'h3ff, 1'b0, 1'b1,
              pins(0, 0, 0, 0, 1, 0, 10'h3ff, 0));
      add_row(OP_SET_DELAY, 1'b0, 10'h3ff, 1'b1, 1'b1,
              pins(0, 0, 0, 0, 1, 0, 10'h3ff, 1));
      add_row(OP_TICK, 1'b0, 10'h000, 1'b0, 1'b1, pins(1, 0, 0, 0, 1, 0, 10'h3ff, 0));
      add_row(OP_TICK, 1'b1, 10'h3ff, 1'b1, 1'b1, pins(1, 1, 0, 0, 1, 0, 10'h3ff, 0));
      add_row(OP_SET_ENABLE, 1'b0, 10'h155, 1'b0, 1'b1,
              pins(0, 0, 0, 1, 1, 0, 10'h3ff, 0));
      add_row(OP_TICK, 1'b0, 10'h2aa, 1'b0, 1'b0, '0);
      add_row(OP_UNUSED, 1'b1, 10'h155, 1'b0, 1'b0, '0);
      repeat (4) add_row(OP_TICK, 1'b1, 10'h000, 1'b1, 1'b0, '0);
      add_row(OP_SET_DELAY, 1'b1, 10'h000, 1'b0, 1'b1,
              pins(0, 0, 0, 1, 1, 0, 10'h3ff, 1));
      add_row(OP_SET_ENABLE, 1'b0, 10'h000, 1'b1, 1'b0, '0);
      repeat (4) add_row(OP_TICK, 1'b0, 10'h000, 1'b0, 1'b0, '0);

      foreach (stim_rows[i]) begin
         rsp_type pred;
         pred = pin_sequence_step(stim_rows[i].req);
         expected_pins.push_back(stim_rows[i].known ? stim_rows[i].rsp : pred);
         send_beat(stim_rows[i].req);
      end

      // Random: mostly full loads of random words, with noise mixed in
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 3) == 0)
            dv = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
         else
            dv = 10'($urandom_range(0, 1023));
         r.channel     = 1'($urandom_range(0, 1));
         r.delay_value = dv;
         r.enable_flag = 1'($urandom_range(0, 1));
         if (loading)
            r.operation = (pick < 90) ? OP_TICK : (pick < 93) ? OP_SET_DELAY :
                          (pick < 97) ? OP_SET_ENABLE : OP_UNUSED;
         else
            r.operation = (pick < 50) ? OP_SET_DELAY : (pick < 70) ? OP_TICK :
                          (pick < 85) ? OP_SET_ENABLE : OP_UNUSED;
         if (r.operation == OP_SET_DELAY || r.operation == OP_SET_ENABLE ||
             (r.operation == OP_TICK && loading))
            useful++;
         quiet = (useful >= QUIET_AFTER);
         expected_pins.push_back(pin_sequence_step(r));
         send_beat(r);
      end
      req_chan.valid <= 1'b0;

      // Drain, then keep the clock running to catch any stray beat
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d request beats sent, %0d responses checked", beats_sent, beats_checked);
      $display("%0d three-pass loads completed, %0d set-delay requests refused",
               loads_done, refusals);
      if (mismatch_count == 0) begin
         $display("fine_delay_serial_loader_test passed");
      end else begin
         $display("fine_delay_serial_loader_test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
